// File: design/fls16_pkg.sv
`default_nettype none

package fls16_pkg;

  // Frame geometry: header, payload, then two checksum bytes (high first)
  localparam int unsigned FRAME_LEN = 67;

  localparam logic [7:0] LAST_POS  = 8'(FRAME_LEN - 1);
  localparam logic [7:0] CHECK_POS = 8'(FRAME_LEN - 2);

  localparam logic [7:0] HEADER_RESET = 8'd200;

  // Status word returned for every received byte
  typedef struct packed {
    logic [7:0]  byte_echo;
    logic        in_frame;
    logic [7:0]  frame_index;
    logic        frame_end;
    logic        frame_ok;
    logic [15:0] header_errors;
    logic [15:0] checksum_errors;
  } status_t;

endpackage

`default_nettype wire

// File: design/fls16_if.sv
`default_nettype none

// Received byte channel
interface fls16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// Status channel, one word per received byte
interface fls16_status_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_echo;
  logic        in_frame;
  logic [7:0]  frame_index;
  logic        frame_end;
  logic        frame_ok;
  logic [15:0] header_errors;
  logic [15:0] checksum_errors;

  modport source (output valid, output byte_echo, output in_frame, output frame_index,
                  output frame_end, output frame_ok, output header_errors,
                  output checksum_errors, input ready);
  modport sink   (input valid, input byte_echo, input in_frame, input frame_index,
                  input frame_end, input frame_ok, input header_errors,
                  input checksum_errors, output ready);
endinterface

// Header byte configuration write channel
interface fls16_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] header_byte;

  modport source (output valid, output header_byte, input ready);
  modport sink   (input valid, input header_byte, output ready);
endinterface

`default_nettype wire

// File: design/fls16_in_reg.sv
`default_nettype none

module fls16_in_reg (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       up_valid,
  output logic            up_ready,
  input  wire logic [7:0] up_byte,
  output logic            dn_valid,
  input  wire logic       dn_ready,
  output logic [7:0]      dn_byte
);
  import fls16_pkg::*;

  logic       valid;
  logic [7:0] rx_hold;

  // Take a new word when empty or when the held word moves on this cycle
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_byte  = rx_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Hold the byte payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      rx_hold <= up_byte;
    end
  end

endmodule

`default_nettype wire

// File: design/fls16_frame_core.sv
`default_nettype none

module fls16_frame_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire logic [7:0]      rx_byte,
  input  wire logic [7:0]      header_byte,
  output fls16_pkg::status_t   res
);
  import fls16_pkg::*;

  logic        reading;
  logic [7:0]  byte_count;
  logic [15:0] running_sum;
  logic [7:0]  check_high;
  logic [15:0] hdr_cnt;
  logic [15:0] chk_cnt;

  logic        reading_next;
  logic [7:0]  byte_count_next;
  logic [15:0] running_sum_next;
  logic [7:0]  check_high_next;
  logic [15:0] hdr_cnt_next;
  logic [15:0] chk_cnt_next;

  // Frame tracking and checksum compare for the byte at the head
  always_comb begin
    reading_next     = reading;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    check_high_next  = check_high;
    hdr_cnt_next     = hdr_cnt;
    chk_cnt_next     = chk_cnt;

    res.byte_echo   = rx_byte;
    res.in_frame    = 1'b0;
    res.frame_index = 8'd0;
    res.frame_end   = 1'b0;
    res.frame_ok    = 1'b0;

    if (!reading) begin
      if (rx_byte == header_byte) begin
        reading_next     = 1'b1;
        byte_count_next  = 8'd1;
        running_sum_next = {8'd0, rx_byte};
        check_high_next  = 8'd0;
        res.in_frame     = 1'b1;
      end else begin
        hdr_cnt_next = hdr_cnt + 16'd1;
      end
    end else begin
      res.in_frame    = 1'b1;
      res.frame_index = byte_count;
      if (byte_count >= LAST_POS) begin
        // Last byte: low half of the checksum
        res.frame_end = 1'b1;
        if ({check_high, rx_byte} == running_sum) begin
          res.frame_ok = 1'b1;
        end else begin
          chk_cnt_next = chk_cnt + 16'd1;
        end
        reading_next    = 1'b0;
        byte_count_next = 8'd0;
      end else begin
        if (byte_count == CHECK_POS) begin
          check_high_next = rx_byte;
        end else begin
          running_sum_next = running_sum + {8'd0, rx_byte};
        end
        byte_count_next = byte_count + 8'd1;
      end
    end

    res.header_errors   = hdr_cnt_next;
    res.checksum_errors = chk_cnt_next;
  end

  // Advance the frame state once per byte passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      reading     <= 1'b0;
      byte_count  <= 8'd0;
      running_sum <= 16'd0;
      check_high  <= 8'd0;
      hdr_cnt     <= 16'd0;
      chk_cnt     <= 16'd0;
    end else if (fire) begin
      reading     <= reading_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      check_high  <= check_high_next;
      hdr_cnt     <= hdr_cnt_next;
      chk_cnt     <= chk_cnt_next;
    end
  end

  a_end_in_frame: assert property (@(posedge clk) disable iff (rst)
    res.frame_end |-> res.in_frame)
    else $error("frame end reported outside a frame");

  a_ok_on_end: assert property (@(posedge clk) disable iff (rst)
    res.frame_ok |-> res.frame_end)
    else $error("checksum pass reported before the last byte");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    reading |-> (byte_count != 8'd0) && (byte_count <= LAST_POS))
    else $error("byte count out of range inside a frame");

  a_hdr_count: assert property (@(posedge clk) disable iff (rst)
    fire && !res.in_frame |=> hdr_cnt == $past(hdr_cnt) + 16'd1)
    else $error("rejected byte did not bump the header error count");

endmodule

`default_nettype wire

// File: design/fls16_out_reg.sv
`default_nettype none

module fls16_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire fls16_pkg::status_t up_word,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output fls16_pkg::status_t   dn_word
);
  import fls16_pkg::*;

  logic    valid;
  status_t word;

  // Refill while empty or while the receiver takes the held word
  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_word  = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  // Hold the status payload
  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word <= up_word;
    end
  end

endmodule

`default_nettype wire

// File: design/fixed_length_frame_sum16_checker.sv
// Fixed-length frame checker with a 16-bit sum checksum.
//
// Channels: rx carries one received byte per word; status returns one word
// per byte (byte echo, frame flag and index, end and pass flags, and the two
// wrapping error counts); cfg writes the header byte that opens a frame.
// cfg.ready is always high; write it only while no byte is in flight.
//
// A byte accepted on rx sits in the input register, is loaded into the result
// register once that register can take it, and its status word is offered
// from there. Throughput is one byte per cycle while the receiver takes the
// status words; the frame state is updated between the two registers, as the
// byte moves into the result register.
//
// Reset (rst, synchronous): waiting for a header, counters cleared, header
// byte back to 200, both registers empty.
//
// When the receiver stalls, the result register holds its word and the input
// register fills behind it; rx.ready then drops after two words are buffered
// and rises again the cycle the status word is taken.
`default_nettype none

module fixed_length_frame_sum16_checker (
  input wire logic        clk,
  input wire logic        rst,
  fls16_byte_if.sink      rx,
  fls16_status_if.source  status,
  fls16_cfg_if.sink       cfg
);
  import fls16_pkg::*;

  logic       header_byte;
  logic [7:0] header_reg;
  logic       s1_valid;
  logic       s1_ready;
  logic [7:0] s1_byte;
  logic       fire;
  logic       res_ready;
  status_t    res;
  status_t    out_word;

  // Header byte register
  assign cfg.ready   = 1'b1;
  assign header_byte = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_reg <= HEADER_RESET;
    end else if (cfg.valid && cfg.ready && header_byte) begin
      header_reg <= cfg.header_byte;
    end
  end

  fls16_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .up_valid (rx.valid),
    .up_ready (rx.ready),
    .up_byte  (rx.rx_byte),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_byte  (s1_byte)
  );

  // Advance the frame state when the byte moves into the result register
  assign s1_ready = res_ready;
  assign fire     = s1_valid && res_ready;

  fls16_frame_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .rx_byte     (s1_byte),
    .header_byte (header_reg),
    .res         (res)
  );

  fls16_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (res_ready),
    .up_word  (res),
    .dn_valid (status.valid),
    .dn_ready (status.ready),
    .dn_word  (out_word)
  );

  assign status.byte_echo       = out_word.byte_echo;
  assign status.in_frame        = out_word.in_frame;
  assign status.frame_index     = out_word.frame_index;
  assign status.frame_end       = out_word.frame_end;
  assign status.frame_ok        = out_word.frame_ok;
  assign status.header_errors   = out_word.header_errors;
  assign status.checksum_errors = out_word.checksum_errors;

endmodule

`default_nettype wire
